### sv/loop_detector_frame_parser_macros.svh
// ----------------------------------------------------------------------------
// Loop detector frame parser: assertion macros
// Shared concurrent assertion shorthands for the checker.
// ----------------------------------------------------------------------------
`ifndef LOOP_DETECTOR_FRAME_PARSER_MACROS_SVH
`define LOOP_DETECTOR_FRAME_PARSER_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define LFP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("loop detector frame parser: assertion failed");

// Next-cycle implication, disabled while in reset
`define LFP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("loop detector frame parser: assertion failed");

`endif

### sv/lfp_pkg.sv
// ----------------------------------------------------------------------------
// Loop detector frame parser package
// Payload types and frame format constants.
// ----------------------------------------------------------------------------
package lfp_pkg;

	localparam int unsigned HELD_MAX  = 5;   // bytes held ahead of the incoming one
	localparam int unsigned FILL_W    = 3;   // holds 0..HELD_MAX
	localparam int unsigned COUNTER_W = 24;
	localparam int unsigned TOTAL_W   = 64;
	localparam int unsigned STATUS_W  = 12;

	localparam logic [3:0] MARK_VALUE = 4'hA;  // low nibble of the first frame byte

	typedef struct packed {
		logic [7:0] rx_byte;
	} rx_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] loop_status;
		logic [TOTAL_W-1:0]  elapsed_ticks;
	} frame_item_t;

endpackage

### sv/lfp_stream_if.sv
// ----------------------------------------------------------------------------
// Loop detector frame parser stream interface
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface lfp_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### sv/loop_detector_frame_parser.sv
// ----------------------------------------------------------------------------
// Loop detector frame parser
// Slides a six-byte window over the detector byte stream, checks the frame
// mark and XOR sum, and reports loop status with the running tick total.
// ----------------------------------------------------------------------------
//  channel       | role   | payload
//  --------------+--------+--------------------------------------------
//  byte_stream   | sink   | rx_byte (8 bits)
//  frame_stream  | source | loop_status (12 bits), elapsed_ticks (64 bits)
//
//  One byte is taken per cycle while the input stage is not held; the byte
//  that completes a valid frame waits in the input stage, and the result
//  register loads when that stage advances, so the frame can then transfer.
//  The rate is set by the single input stage: a byte waits there only while
//  it completes a frame and the result register still holds an untaken frame.
//  arst_n clears the window fill, the counter history, the total and all
//  valid flags.
// ----------------------------------------------------------------------------
module loop_detector_frame_parser
	import lfp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	lfp_stream_if.sink       byte_stream,
	lfp_stream_if.source     frame_stream
);

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;

	// window and history
	logic [7:0]           window_q [HELD_MAX];
	logic [FILL_W-1:0]    fill_q;
	logic [COUNTER_W-1:0] prev_counter_q;
	logic [TOTAL_W-1:0]   total_q;

	// result register
	logic        out_valid_q;
	frame_item_t out_data_q;

	logic                 full;
	logic [7:0]           parity;
	logic                 frame_ok;
	logic                 advance;
	logic [COUNTER_W-1:0] counter;
	logic [COUNTER_W-1:0] delta;
	logic [TOTAL_W-1:0]   total_next;

	// check the held bytes against the byte in the input stage
	always_comb begin
		full   = (fill_q == FILL_W'(HELD_MAX));
		parity = window_q[0] ^ window_q[1] ^ window_q[2] ^ window_q[3] ^ window_q[4];
		frame_ok = full && (window_q[0][3:0] == MARK_VALUE) && (parity == byte_s1);
		// counter is little endian over bytes 2 to 4; difference wraps at 2^24
		counter    = {window_q[4], window_q[3], window_q[2]};
		delta      = counter - prev_counter_q;
		total_next = total_q + TOTAL_W'(delta);
	end

	// hold the stage only when a frame result has nowhere to go
	assign advance = valid_s1 && !(frame_ok && out_valid_q && !frame_stream.ready);
	assign byte_stream.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_stream.ready) begin
			valid_s1 <= byte_stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_stream.valid && byte_stream.ready) begin
			byte_s1 <= byte_stream.data.rx_byte;
		end
	end

	// window update: fill, empty on a frame, or drop the oldest byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q         <= '0;
			prev_counter_q <= '0;
			total_q        <= '0;
		end else if (advance) begin
			if (!full) begin
				fill_q <= fill_q + FILL_W'(1);
			end else if (frame_ok) begin
				fill_q         <= '0;
				prev_counter_q <= counter;
				total_q        <= total_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (!full) begin
				for (int k = 0; k < HELD_MAX; k++) begin
					if (fill_q == FILL_W'(k)) begin
						window_q[k] <= byte_s1;
					end
				end
			end else if (!frame_ok) begin
				for (int k = 0; k < HELD_MAX - 1; k++) begin
					window_q[k] <= window_q[k+1];
				end
				window_q[HELD_MAX-1] <= byte_s1;
			end
		end
	end

	// result register: load on a frame, drop once transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && frame_ok) begin
			out_valid_q <= 1'b1;
		end else if (frame_stream.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && frame_ok) begin
			out_data_q.loop_status   <= {window_q[1], window_q[0][7:4]};
			out_data_q.elapsed_ticks <= total_next;
		end
	end

	assign frame_stream.valid = out_valid_q;
	assign frame_stream.data  = out_data_q;

endmodule

### sv/lfp_checker.sv
// ----------------------------------------------------------------------------
// Loop detector frame parser checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "loop_detector_frame_parser_macros.svh"

module lfp_checker
	import lfp_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input frame_item_t out_data
);

	`LFP_ASSERT_NXT(a_out_valid_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`LFP_ASSERT_NXT(a_out_data_hold, clk, arst_n, out_valid && !out_ready, $stable(out_data))
	// input stalls only behind an untaken result
	`LFP_ASSERT_IMP(a_stall_cause, clk, arst_n, !in_ready, out_valid && !out_ready)
	// a fresh result is preceded by a byte transfer that passed through the input stage
	`LFP_ASSERT_IMP(a_result_source, clk, arst_n, $rose(out_valid), $past(in_valid && in_ready, 2))

endmodule

bind loop_detector_frame_parser lfp_checker u_lfp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (byte_stream.valid),
	.in_ready  (byte_stream.ready),
	.out_valid (frame_stream.valid),
	.out_ready (frame_stream.ready),
	.out_data  (frame_stream.data)
);
